// ----- hdl/sct_pkg.sv -----
// Shared types and constants for the source character tokenizer.
// Holds token kind codes, pending class states and the keyword table.
// No dependencies.
`timescale 1ns / 1ps

package sct_pkg;

  localparam int KIND_W = 6;
  localparam int KW_COUNT = 15;
  localparam int KW_MAX_CHARS = 6;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_IDENT   = 6'd15;
  localparam kind_t KIND_INT     = 6'd16;
  localparam kind_t KIND_EQEQ    = 6'd17;
  localparam kind_t KIND_ASSIGN  = 6'd18;
  localparam kind_t KIND_SEMI    = 6'd19;
  localparam kind_t KIND_LPAREN  = 6'd20;
  localparam kind_t KIND_RPAREN  = 6'd21;
  localparam kind_t KIND_LBRACE  = 6'd22;
  localparam kind_t KIND_RBRACE  = 6'd23;
  localparam kind_t KIND_COMMA   = 6'd24;
  localparam kind_t KIND_PLUS    = 6'd25;
  localparam kind_t KIND_MINUS   = 6'd26;
  localparam kind_t KIND_STAR    = 6'd27;
  localparam kind_t KIND_SLASH   = 6'd28;
  localparam kind_t KIND_LESS    = 6'd29;
  localparam kind_t KIND_GREATER = 6'd30;
  localparam kind_t KIND_NOTEQ   = 6'd31;
  localparam kind_t KIND_ILLEGAL = 6'd32;
  localparam kind_t KIND_END     = 6'd33;

  typedef enum logic [2:0] {
    PC_NONE   = 3'd0,
    PC_IDENT  = 3'd1,
    PC_NUMBER = 3'd2,
    PC_EQ     = 3'd3,
    PC_BANG   = 3'd4
  } pend_class_t;

  // Keyword text is right-justified: the last character sits in bits [7:0].
  localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    48'("def"), 48'("class"), 48'("struct"), 48'("return"), 48'("int32"),
    48'("float"), 48'("bool"), 48'("char"), 48'("list"), 48'("if"),
    48'("elif"), 48'("else"), 48'("true"), 48'("false"), 48'("while")
  };
  localparam int KW_LEN [KW_COUNT] = '{3, 5, 6, 6, 5, 5, 4, 4, 4, 2, 4, 4, 4, 5, 5};

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h3B:   k = KIND_SEMI;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h2C:   k = KIND_COMMA;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h3C:   k = KIND_LESS;
      8'h3E:   k = KIND_GREATER;
      default: k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/sct_core.sv -----
// Tokenizer state and per-byte step logic; emits up to two result words per byte.
// Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_core #(
  parameter int KEYWORD_CHARS = 6,
  parameter int POS_WIDTH = 32,
  parameter int LEN_WIDTH = 16,
  parameter int RES_W = sct_pkg::KIND_W + POS_WIDTH + LEN_WIDTH + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       ch,
  input  logic             eoi,
  output logic [1:0]       push_n,
  output logic [RES_W-1:0] push_d0,
  output logic [RES_W-1:0] push_d1
);
  import sct_pkg::*;

  pend_class_t pc_r, pc_nxt;
  logic [LEN_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [POS_WIDTH-1:0] tb_r, tb_nxt;
  logic [POS_WIDTH-1:0] bp_r, bp_nxt;
  logic [7:0] kb_r [KEYWORD_CHARS];

  logic kb_we;
  logic [LEN_WIDTH-1:0] kb_sel;

  logic term, is_space, is_digit, is_alpha, ident_ch, start_cls;
  logic fl_valid, fr_emit;
  kind_t fl_kind, id_kind;
  logic [LEN_WIDTH-1:0] fl_len, cnt_inc;
  logic kw_same, kw_hit;

  logic fa, fb;
  kind_t ka, kb;
  logic [POS_WIDTH-1:0] sa, sb;
  logic [LEN_WIDTH-1:0] la, lb;

  assign term     = eoi || (ch == 8'd0);
  assign is_space = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
  assign ident_ch = is_alpha || is_digit || (ch == 8'h5F);
  assign start_cls = ident_ch || (ch == 8'h3D) || (ch == 8'h21);
  assign fr_emit  = !is_space && !start_cls;
  assign cnt_inc  = (cnt_r == {LEN_WIDTH{1'b1}}) ? cnt_r : cnt_r + LEN_WIDTH'(1);

  always_comb begin
    id_kind = KIND_IDENT;
    kw_hit = 1'b0;
    kw_same = 1'b0;
    if (32'(cnt_r) <= KEYWORD_CHARS) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        kw_same = (32'(cnt_r) == KW_LEN[k]);
        for (int i = 0; i < KW_MAX_CHARS; i++) begin
          if (i < KW_LEN[k] && kb_r[i] != KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]) begin
            kw_same = 1'b0;
          end
        end
        if (kw_same && !kw_hit) begin
          kw_hit = 1'b1;
          id_kind = KIND_W'(k);
        end
      end
    end
  end

  always_comb begin
    fl_valid = (pc_r != PC_NONE);
    fl_len = LEN_WIDTH'(1);
    case (pc_r)
      PC_IDENT: begin
        fl_kind = id_kind;
        fl_len = cnt_r;
      end
      PC_NUMBER: begin
        fl_kind = KIND_INT;
        fl_len = cnt_r;
      end
      PC_EQ:   fl_kind = KIND_ASSIGN;
      PC_BANG: fl_kind = KIND_ILLEGAL;
      default: fl_kind = KIND_ILLEGAL;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    cnt_nxt = cnt_r;
    tb_nxt = tb_r;
    bp_nxt = bp_r;
    kb_we = 1'b0;
    kb_sel = cnt_r;
    fa = 1'b0;
    fb = 1'b0;
    ka = fl_kind;
    sa = tb_r;
    la = fl_len;
    kb = KIND_END;
    sb = bp_r;
    lb = '0;
    if (take) begin
      if (term) begin
        fa = fl_valid;
        fb = 1'b1;
        pc_nxt = PC_NONE;
        cnt_nxt = '0;
        tb_nxt = '0;
        bp_nxt = '0;
      end else begin
        bp_nxt = bp_r + POS_WIDTH'(1);
        if (pc_r == PC_IDENT && ident_ch) begin
          kb_we = (32'(cnt_r) < KEYWORD_CHARS);
          cnt_nxt = cnt_inc;
        end else if (pc_r == PC_NUMBER && is_digit) begin
          cnt_nxt = cnt_inc;
        end else if ((pc_r == PC_EQ || pc_r == PC_BANG) && ch == 8'h3D) begin
          fa = 1'b1;
          ka = (pc_r == PC_EQ) ? KIND_EQEQ : KIND_NOTEQ;
          la = LEN_WIDTH'(2);
          pc_nxt = PC_NONE;
        end else begin
          fa = fl_valid;
          pc_nxt = PC_NONE;
          if (!is_space) begin
            tb_nxt = bp_r;
            cnt_nxt = LEN_WIDTH'(1);
          end
          if (is_alpha || ch == 8'h5F) begin
            pc_nxt = PC_IDENT;
            kb_we = 1'b1;
            kb_sel = '0;
          end else if (is_digit) begin
            pc_nxt = PC_NUMBER;
          end else if (ch == 8'h3D) begin
            pc_nxt = PC_EQ;
          end else if (ch == 8'h21) begin
            pc_nxt = PC_BANG;
          end
          if (fr_emit) begin
            fb = 1'b1;
            kb = single_kind(ch);
            lb = LEN_WIDTH'(1);
          end
        end
      end
    end
  end

  always_comb begin
    push_n = {1'b0, fa} + {1'b0, fb};
    push_d1 = {kb, sb, lb, 1'b1};
    push_d0 = fa ? {ka, sa, la, !fb} : push_d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_NONE;
      cnt_r <= '0;
      tb_r <= '0;
      bp_r <= '0;
    end else begin
      pc_r <= pc_nxt;
      cnt_r <= cnt_nxt;
      tb_r <= tb_nxt;
      bp_r <= bp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (kb_we && 32'(kb_sel) == i) begin
        kb_r[i] <= ch;
      end
    end
  end

endmodule

// ----- hdl/sct_queue.sv -----
// Small result queue that takes up to two words per cycle and hands out one.
// No package dependencies; it stores the words without looking inside them.
`timescale 1ns / 1ps

module sct_queue #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  logic [WIDTH-1:0] push_d0,
  input  logic [WIDTH-1:0] push_d1,
  output logic             room2,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_d
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  assign wp1 = bump(wp_r);
  assign pop = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_d = mem_r[rp_r];
  assign room2 = (32'(cnt_r) <= DEPTH - 2);

  always_comb begin
    wp_nxt = wp_r;
    if (push_n == 2'd1) begin
      wp_nxt = wp1;
    end else if (push_n == 2'd2) begin
      wp_nxt = bump(wp1);
    end
    rp_nxt = pop ? bump(rp_r) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wp_r] <= push_d0;
    end
    if (push_n == 2'd2) begin
      mem_r[wp1] <= push_d1;
    end
  end

endmodule

// ----- hdl/source_char_tokenizer_unit.sv -----
// Top level of the source character tokenizer: step logic plus result queue.
// Depends on sct_pkg, sct_core and sct_queue.
// Each token is written to the result queue when the byte that ends it is taken.
// Throughput: one byte per cycle while in_ready is high; a byte can close two tokens.
// in_ready is high while the four-word result queue has two free words.
// Synchronous reset clears the pending token, the position and the queue.
`timescale 1ns / 1ps

module source_char_tokenizer_unit #(
  parameter int KEYWORD_CHARS = 6,
  parameter int POS_WIDTH = 32,
  parameter int LEN_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_ch,
  input  logic                      in_end_of_input,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sct_pkg::KIND_W-1:0] out_token_kind,
  output logic [POS_WIDTH-1:0]      out_token_start,
  output logic [LEN_WIDTH-1:0]      out_token_length,
  output logic                      out_last
);
  import sct_pkg::*;

  localparam int RES_W = KIND_W + POS_WIDTH + LEN_WIDTH + 1;
  localparam int QUEUE_DEPTH = 4;

  logic take;
  logic [1:0] push_n;
  logic [RES_W-1:0] push_d0, push_d1, pop_d;

  assign take = in_valid && in_ready;

  sct_core #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POS_WIDTH(POS_WIDTH),
    .LEN_WIDTH(LEN_WIDTH),
    .RES_W(RES_W)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .take(take),
    .ch(in_ch),
    .eoi(in_end_of_input),
    .push_n(push_n),
    .push_d0(push_d0),
    .push_d1(push_d1)
  );

  sct_queue #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_n(push_n),
    .push_d0(push_d0),
    .push_d1(push_d1),
    .room2(in_ready),
    .pop_valid(out_valid),
    .pop_ready(out_ready),
    .pop_d(pop_d)
  );

  assign {out_token_kind, out_token_start, out_token_length, out_last} = pop_d;

endmodule

// ----- test/source_char_tokenizer_unit_tb.sv -----
// Self-checking testbench for source_char_tokenizer_unit: byte streams in, tokens out.
// A scoreboard class predicts each token and checks it; depends on sct_pkg and the RTL.
// Both handshakes idle at random, with a long receiver hold-off and a drain pause.
`timescale 1ns / 1ps

module source_char_tokenizer_unit_tb;
  import sct_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_rec_t;

  class token_scoreboard;
    pend_class_t pend;
    logic [7:0]  kbuf [KW_MAX_CHARS];
    logic [15:0] len_cnt;
    logic [31:0] tok_start;
    logic [31:0] byte_pos;
    token_rec_t  expected_tokens [$];
    int          errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      pend = PC_NONE;
      len_cnt = '0;
      tok_start = '0;
      byte_pos = '0;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function void add(kind_t kind, logic [31:0] start, logic [15:0] len);
      token_rec_t t;
      t.kind = kind;
      t.start = start;
      t.len = len;
      t.last = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    function void mark_last();
      token_rec_t t;
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    endfunction

    function kind_t keyword_kind();
      bit same;
      if (len_cnt > KW_MAX_CHARS) return KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
        if (KW_LEN[k] != len_cnt) continue;
        same = 1'b1;
        for (int i = 0; i < KW_LEN[k]; i++) begin
          if (kbuf[i] != KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]) same = 1'b0;
        end
        if (same) return kind_t'(k);
      end
      return KIND_IDENT;
    endfunction

    function kind_t operator_kind(logic [7:0] c);
      case (c)
        ";":     return KIND_SEMI;
        "(":     return KIND_LPAREN;
        ")":     return KIND_RPAREN;
        "{":     return KIND_LBRACE;
        "}":     return KIND_RBRACE;
        ",":     return KIND_COMMA;
        "+":     return KIND_PLUS;
        "-":     return KIND_MINUS;
        "*":     return KIND_STAR;
        "/":     return KIND_SLASH;
        "<":     return KIND_LESS;
        ">":     return KIND_GREATER;
        default: return KIND_ILLEGAL;
      endcase
    endfunction

    function void flush_pending();
      case (pend)
        PC_IDENT:  add(keyword_kind(), tok_start, len_cnt);
        PC_NUMBER: add(KIND_INT, tok_start, len_cnt);
        PC_EQ:     add(KIND_ASSIGN, tok_start, 16'd1);
        PC_BANG:   add(KIND_ILLEGAL, tok_start, 16'd1);
        default: ;
      endcase
      pend = PC_NONE;
    endfunction

    function void open_token(logic [7:0] c);
      if (is_space(c)) return;
      tok_start = byte_pos;
      len_cnt = 16'd1;
      if (is_alpha(c) || c == "_") begin
        pend = PC_IDENT;
        kbuf[0] = c;
      end else if (is_digit(c)) begin
        pend = PC_NUMBER;
      end else if (c == "=") begin
        pend = PC_EQ;
      end else if (c == "!") begin
        pend = PC_BANG;
      end else begin
        add(operator_kind(c), byte_pos, 16'd1);
      end
    endfunction

    // Called once for every byte accepted on the input side.
    function void lex_byte(logic [7:0] c, logic eoi);
      int first;
      first = expected_tokens.size();
      if (eoi || c == 8'd0) begin
        flush_pending();
        add(KIND_END, byte_pos, 16'd0);
        mark_last();
        clear_state();
        return;
      end
      case (pend)
        PC_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (len_cnt < KW_MAX_CHARS) kbuf[len_cnt] = c;
            if (len_cnt != '1) len_cnt = len_cnt + 16'd1;
          end else begin
            flush_pending();
            open_token(c);
          end
        end
        PC_NUMBER: begin
          if (is_digit(c)) begin
            if (len_cnt != '1) len_cnt = len_cnt + 16'd1;
          end else begin
            flush_pending();
            open_token(c);
          end
        end
        PC_EQ, PC_BANG: begin
          if (c == "=") begin
            add(pend == PC_EQ ? KIND_EQEQ : KIND_NOTEQ, tok_start, 16'd2);
            pend = PC_NONE;
          end else begin
            flush_pending();
            open_token(c);
          end
        end
        default: open_token(c);
      endcase
      byte_pos = byte_pos + 32'd1;
      if (expected_tokens.size() > first) mark_last();
    endfunction

    task report(string what);
      if (errors < 100) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_token(kind_t kind, logic [31:0] start, logic [15:0] len, logic last);
      token_rec_t exp;
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected token kind %0d start %0d len %0d", kind, start, len));
        return;
      end
      exp = expected_tokens.pop_front();
      if (kind !== exp.kind)
        report($sformatf("kind %0d, expected %0d (start %0d)", kind, exp.kind, exp.start));
      if (start !== exp.start)
        report($sformatf("start %0d, expected %0d", start, exp.start));
      if (len !== exp.len)
        report($sformatf("length %0d, expected %0d (start %0d)", len, exp.len, exp.start));
      if (last !== exp.last)
        report($sformatf("last %0b, expected %0b (start %0d)", last, exp.last, exp.start));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = 8'd0;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [KIND_W-1:0] out_token_kind;
  logic [31:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_last;

  token_scoreboard sb = new();
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_request = 1'b0;
  int bytes_sent = 0;
  int cycles = 0;

  source_char_tokenizer_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last         (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_token(out_token_kind, out_token_start, out_token_length, out_last);
    end
  end

  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] c, logic eoi);
    if (tx_idle_on && $urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 19));
    @(negedge clk);
    in_valid <= 1'b1;
    in_ch <= c;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.lex_byte(c, eoi);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] word_char(bit head);
    int r;
    r = head ? $urandom_range(0, 53) : $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (head || r >= 62) return "_";
    return 8'("0" + r - 52);
  endfunction

  task automatic send_keyword(int k);
    for (int i = 0; i < KW_LEN[k]; i++) send_byte(KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8], 1'b0);
  endtask

  task automatic send_lexeme();
    int pick;
    int n;
    int r;
    string ops;
    ops = "=;(){},+-*/<>!";
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      send_keyword($urandom_range(0, KW_COUNT - 1));
      if ($urandom_range(0, 5) == 0) send_byte(word_char(1'b0), 1'b0);
    end else if (pick < 36) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
      send_byte(word_char(1'b1), 1'b0);
      for (int i = 1; i < n; i++) send_byte(word_char(1'b0), 1'b0);
    end else if (pick < 48) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
    end else if (pick < 66) begin
      r = $urandom_range(0, ops.len() + 1);
      if (r == ops.len()) send_text("==");
      else if (r == ops.len() + 1) send_text("!=");
      else send_byte(ops[r], 1'b0);
    end else if (pick < 90) begin
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(8, 13);
        send_byte(r == 8 ? 8'd32 : 8'(r), 1'b0);
      end
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(1, 255)), 1'b0);
    end else if ($urandom_range(0, 1) == 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_byte(8'd0, 1'b0);
    end
  endtask

  task automatic send_random(int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_lexeme();
  endtask

  task automatic long_token(bit number, int n);
    send_byte(number ? 8'("1") : word_char(1'b1), 1'b0);
    for (int i = 1; i < n; i++)
      send_byte(number ? 8'("0" + $urandom_range(0, 9)) : word_char(1'b0), 1'b0);
    send_byte(8'd32, 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text("12ab!x!===");
    send_byte("=", 1'b0);
    send_byte(8'd9, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("structs");
    send_byte(8'hA5, 1'b1);
    send_byte("q", 1'b0);
    send_byte(8'd0, 1'b0);

    send_random(400);

    tx_idle_on = 1'b0;
    hold_request = 1'b1;
    send_random(60);
    wait_drained();
    tx_idle_on = 1'b1;

    send_random(400);

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    long_token(1'b1, 20);
    long_token(1'b0, 20);
    send_random(130);
    send_byte(8'd0, 1'b1);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
